[src/seconds_to_calendar_time_assert.svh]
// ----------------------------------------------------------------------------
// seconds_to_calendar_time assertion macros
// concurrent assertion shorthands used by the checker
// ----------------------------------------------------------------------------
`ifndef SECONDS_TO_CALENDAR_TIME_ASSERT_SVH
`define SECONDS_TO_CALENDAR_TIME_ASSERT_SVH

// property checked on the rising clock, switched off while reset is low
`define S2CT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on the rising clock, also during reset
`define S2CT_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/s2ct_pkg.sv]
// ----------------------------------------------------------------------------
// s2ct_pkg
// shared widths, constants, queue entry type and month table
// ----------------------------------------------------------------------------
package s2ct_pkg;

  // field widths
  localparam int unsigned SECS_W  = 25;
  localparam int unsigned MICRO_W = 20;
  localparam int unsigned YEAR_W  = 16;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned REST_W  = 17;
  localparam int unsigned REM_W   = 12;
  localparam int unsigned MON_W   = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;

  // stream widths
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 48;

  // time constants
  localparam logic [REST_W-1:0]  DAY_SECS    = 17'd86400;
  localparam logic [REM_W-1:0]   HOUR_SECS   = 12'd3600;
  localparam logic [MIN_W-1:0]   MIN_SECS    = 6'd60;
  localparam logic [MICRO_W-1:0] MICRO_MAX   = 20'd999999;
  localparam logic [DOY_W-1:0]   COMMON_DAYS = 9'd365;
  localparam logic [YEAR_W-1:0]  YEAR_RESET  = 16'd2000;

  // reciprocals for constant division: q = (x * RECIP) >> SHIFT
  localparam int unsigned        DAY_RECIP_W  = 18;
  localparam logic [17:0]        DAY_RECIP    = 18'd198841;
  localparam int unsigned        DAY_SHIFT    = 34;
  localparam int unsigned        HOUR_RECIP_W = 16;
  localparam logic [15:0]        HOUR_RECIP   = 16'd37283;
  localparam int unsigned        HOUR_SHIFT   = 27;
  localparam int unsigned        MIN_RECIP_W  = 12;
  localparam logic [11:0]        MIN_RECIP    = 12'd2185;
  localparam int unsigned        MIN_SHIFT    = 17;

  // divisibility by 25 via modular inverse
  localparam logic [YEAR_W-1:0]  INV25     = 16'd23593;
  localparam logic [YEAR_W-1:0]  DIV25_LIM = 16'd2621;

  // month codes
  localparam int unsigned        MONTHS   = 12;
  localparam logic [MON_W-1:0]   FEBRUARY = 4'd1;
  localparam logic [MON_W-1:0]   DECEMBER = 4'd12;
  localparam logic [DAY_W-1:0]   LAST_DAY = 5'd31;
  localparam logic [HOUR_W-1:0]  LAST_HOUR = 5'd23;
  localparam logic [MIN_W-1:0]   LAST_MIN  = 6'd59;
  localparam logic [SEC_W-1:0]   LAST_SEC  = 6'd59;

  // decoupling queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // item handed from front to back
  typedef struct packed {
    logic [DOY_W-1:0]   doy;
    logic [REST_W-1:0]  rest;
    logic [MICRO_W-1:0] micro;
    logic               leap;
    logic               past;
  } entry_t;

  // first day of the year of a month (0 = january)
  function automatic logic [DOY_W-1:0] month_start(input logic [MON_W-1:0] m,
                                                   input logic leap);
    logic [DOY_W-1:0] base;
    case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd334;
    endcase
    if (m > FEBRUARY) begin
      base = base + {{(DOY_W-1){1'b0}}, leap};
    end
    return base;
  endfunction

endpackage

[src/s2ct_queue.sv]
// ----------------------------------------------------------------------------
// s2ct_queue
// short flip-flop queue that decouples front and back
// ----------------------------------------------------------------------------
module s2ct_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  s2ct_pkg::entry_t  push_entry_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output s2ct_pkg::entry_t  pop_entry_o
);

  s2ct_pkg::entry_t                  mem_q [s2ct_pkg::QDEPTH];
  logic [s2ct_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [s2ct_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [s2ct_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  logic                              do_push, do_pop;

  localparam logic [s2ct_pkg::QCNT_W-1:0] FULL = s2ct_pkg::QCNT_W'(s2ct_pkg::QDEPTH);
  localparam logic [s2ct_pkg::QPTR_W-1:0] LAST = s2ct_pkg::QPTR_W'(s2ct_pkg::QDEPTH - 1);

  assign push_ready_o = (cnt_q != FULL);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

[src/s2ct_front.sv]
// ----------------------------------------------------------------------------
// s2ct_front
// accepts timestamps, splits off the day of the year and classifies overflow
// ----------------------------------------------------------------------------
module s2ct_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [s2ct_pkg::SECS_W-1:0]     secs_i,
  input  logic [s2ct_pkg::MICRO_W-1:0]    micro_i,
  input  logic [s2ct_pkg::YEAR_W-1:0]     year_i,
  output logic                            push_valid_o,
  input  logic                            push_ready_i,
  output s2ct_pkg::entry_t                push_entry_o
);

  localparam int unsigned QPROD_W = s2ct_pkg::SECS_W + s2ct_pkg::DAY_RECIP_W;
  localparam int unsigned DPROD_W = s2ct_pkg::DOY_W + s2ct_pkg::REST_W;

  logic                          v_q, v_d;
  logic [s2ct_pkg::SECS_W-1:0]   secs_q;
  logic [s2ct_pkg::MICRO_W-1:0]  micro_q, micro_sat;
  logic [s2ct_pkg::DOY_W-1:0]    qa_q, qa;
  logic                          leap_q, leap;
  logic [QPROD_W-1:0]            qprod;
  logic [2*s2ct_pkg::YEAR_W-1:0] yprod;
  logic                          div25;
  logic [DPROD_W-1:0]            dprod;
  logic [s2ct_pkg::SECS_W-1:0]   diff;
  logic                          wrap;
  logic [s2ct_pkg::DOY_W-1:0]    doy;
  logic [s2ct_pkg::SECS_W-1:0]   rest_wide;

  assign in_ready_o = !v_q || push_ready_i;

  // estimate of the day of the year, low by at most one
  assign qprod = QPROD_W'(secs_i) * QPROD_W'(s2ct_pkg::DAY_RECIP);
  assign qa    = qprod[s2ct_pkg::DAY_SHIFT +: s2ct_pkg::DOY_W];

  // leap year: divisible by 4, and not by 100 unless by 400
  assign yprod = (2*s2ct_pkg::YEAR_W)'(year_i) * (2*s2ct_pkg::YEAR_W)'(s2ct_pkg::INV25);
  assign div25 = (yprod[s2ct_pkg::YEAR_W-1:0] <= s2ct_pkg::DIV25_LIM);
  assign leap  = (year_i[1:0] == 2'b00) && (!div25 || (year_i[3:0] == 4'b0000));

  // fraction clamp
  assign micro_sat = (micro_i > s2ct_pkg::MICRO_MAX) ? s2ct_pkg::MICRO_MAX : micro_i;

  // stage valid
  always_comb begin
    v_d = v_q;
    if (in_ready_o) begin
      v_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      secs_q  <= secs_i;
      micro_q <= micro_sat;
      qa_q    <= qa;
      leap_q  <= leap;
    end
  end

  // correct the estimate and find the rest of the day
  assign dprod     = DPROD_W'(qa_q) * DPROD_W'(s2ct_pkg::DAY_SECS);
  assign diff      = secs_q - dprod[s2ct_pkg::SECS_W-1:0];
  assign wrap      = (diff >= s2ct_pkg::SECS_W'(s2ct_pkg::DAY_SECS));
  assign doy       = qa_q + {{(s2ct_pkg::DOY_W-1){1'b0}}, wrap};
  assign rest_wide = wrap ? (diff - s2ct_pkg::SECS_W'(s2ct_pkg::DAY_SECS)) : diff;

  // queue entry
  always_comb begin
    push_entry_o.doy   = doy;
    push_entry_o.rest  = rest_wide[s2ct_pkg::REST_W-1:0];
    push_entry_o.micro = micro_q;
    push_entry_o.leap  = leap_q;
    push_entry_o.past  = (doy >= (s2ct_pkg::COMMON_DAYS +
                                  {{(s2ct_pkg::DOY_W-1){1'b0}}, leap_q}));
  end

  assign push_valid_o = v_q;

endmodule

[src/s2ct_back.sv]
// ----------------------------------------------------------------------------
// s2ct_back
// four-stage pipeline: month and hour, minute remainder, minute, second
// ----------------------------------------------------------------------------
module s2ct_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            pop_valid_i,
  output logic                            pop_ready_o,
  input  s2ct_pkg::entry_t                pop_entry_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [s2ct_pkg::MON_W-1:0]      month_o,
  output logic [s2ct_pkg::DAY_W-1:0]      day_o,
  output logic [s2ct_pkg::HOUR_W-1:0]     hour_o,
  output logic [s2ct_pkg::MIN_W-1:0]      minute_o,
  output logic [s2ct_pkg::SEC_W-1:0]      second_o,
  output logic [s2ct_pkg::MICRO_W-1:0]    micro_o,
  output logic                            past_o
);

  localparam int unsigned HPROD_W = s2ct_pkg::REST_W + s2ct_pkg::HOUR_RECIP_W;
  localparam int unsigned HSEC_W  = s2ct_pkg::HOUR_W + s2ct_pkg::REM_W;
  localparam int unsigned MPROD_W = s2ct_pkg::REM_W + s2ct_pkg::MIN_RECIP_W;
  localparam int unsigned MSEC_W  = 2 * s2ct_pkg::MIN_W;

  logic b1_v_q, b2_v_q, b3_v_q, o_v_q;
  logic b1_en, b2_en, b3_en, o_en;

  // stage payloads
  logic [s2ct_pkg::MON_W-1:0]    b1_mon_q,  b2_mon_q,  b3_mon_q;
  logic [s2ct_pkg::DAY_W-1:0]    b1_day_q,  b2_day_q,  b3_day_q;
  logic [s2ct_pkg::HOUR_W-1:0]   b1_hour_q, b2_hour_q, b3_hour_q;
  logic [s2ct_pkg::MICRO_W-1:0]  b1_micro_q, b2_micro_q, b3_micro_q;
  logic                          b1_past_q, b2_past_q, b3_past_q;
  logic [s2ct_pkg::REST_W-1:0]   b1_rest_q;
  logic [s2ct_pkg::REM_W-1:0]    b2_rem_q, b3_rem_q;
  logic [s2ct_pkg::MIN_W-1:0]    b3_min_q;

  // combinational results
  logic [s2ct_pkg::MON_W-1:0]    mon_idx;
  logic [s2ct_pkg::DOY_W-1:0]    start;
  logic [s2ct_pkg::DOY_W-1:0]    day_wide;
  logic [HPROD_W-1:0]            hprod;
  logic [HSEC_W-1:0]             hsec;
  logic [s2ct_pkg::REST_W-1:0]   rem_wide;
  logic [MPROD_W-1:0]            mprod;
  logic [MSEC_W-1:0]             msec;
  logic [s2ct_pkg::REM_W-1:0]    sec_wide;

  // stall chain: a stage loads when empty or when its successor loads
  assign o_en        = !o_v_q || out_ready_i;
  assign b3_en       = !b3_v_q || o_en;
  assign b2_en       = !b2_v_q || b3_en;
  assign b1_en       = !b1_v_q || b2_en;
  assign pop_ready_o = b1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
      b3_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (b1_en) b1_v_q <= pop_valid_i;
      if (b2_en) b2_v_q <= b1_v_q;
      if (b3_en) b3_v_q <= b2_v_q;
      if (o_en)  o_v_q  <= b3_v_q;
    end
  end

  // month lookup: last month whose first day is not after the day of the year
  always_comb begin
    mon_idx = '0;
    for (int m = 0; m < s2ct_pkg::MONTHS; m++) begin
      if (pop_entry_i.doy >= s2ct_pkg::month_start(s2ct_pkg::MON_W'(m), pop_entry_i.leap)) begin
        mon_idx = s2ct_pkg::MON_W'(m);
      end
    end
  end

  assign start    = s2ct_pkg::month_start(mon_idx, pop_entry_i.leap);
  assign day_wide = pop_entry_i.doy - start + 1'b1;
  assign hprod    = HPROD_W'(pop_entry_i.rest) * HPROD_W'(s2ct_pkg::HOUR_RECIP);

  // stage 1: month, day and hour
  always_ff @(posedge clk_i) begin
    if (b1_en) begin
      b1_mon_q   <= mon_idx + 1'b1;
      b1_day_q   <= day_wide[s2ct_pkg::DAY_W-1:0];
      b1_hour_q  <= hprod[s2ct_pkg::HOUR_SHIFT +: s2ct_pkg::HOUR_W];
      b1_rest_q  <= pop_entry_i.rest;
      b1_micro_q <= pop_entry_i.micro;
      b1_past_q  <= pop_entry_i.past;
    end
  end

  // stage 2: seconds left within the hour
  assign hsec     = HSEC_W'(b1_hour_q) * HSEC_W'(s2ct_pkg::HOUR_SECS);
  assign rem_wide = b1_rest_q - hsec[s2ct_pkg::REST_W-1:0];

  always_ff @(posedge clk_i) begin
    if (b2_en) begin
      b2_mon_q   <= b1_mon_q;
      b2_day_q   <= b1_day_q;
      b2_hour_q  <= b1_hour_q;
      b2_rem_q   <= rem_wide[s2ct_pkg::REM_W-1:0];
      b2_micro_q <= b1_micro_q;
      b2_past_q  <= b1_past_q;
    end
  end

  // stage 3: minute
  assign mprod = MPROD_W'(b2_rem_q) * MPROD_W'(s2ct_pkg::MIN_RECIP);

  always_ff @(posedge clk_i) begin
    if (b3_en) begin
      b3_mon_q   <= b2_mon_q;
      b3_day_q   <= b2_day_q;
      b3_hour_q  <= b2_hour_q;
      b3_rem_q   <= b2_rem_q;
      b3_min_q   <= mprod[s2ct_pkg::MIN_SHIFT +: s2ct_pkg::MIN_W];
      b3_micro_q <= b2_micro_q;
      b3_past_q  <= b2_past_q;
    end
  end

  // output stage: second, then clamp past the year end
  assign msec     = MSEC_W'(b3_min_q) * MSEC_W'(s2ct_pkg::MIN_SECS);
  assign sec_wide = b3_rem_q - msec;

  always_ff @(posedge clk_i) begin
    if (o_en) begin
      micro_o <= b3_micro_q;
      past_o  <= b3_past_q;
      if (b3_past_q) begin
        month_o  <= s2ct_pkg::DECEMBER;
        day_o    <= s2ct_pkg::LAST_DAY;
        hour_o   <= s2ct_pkg::LAST_HOUR;
        minute_o <= s2ct_pkg::LAST_MIN;
        second_o <= s2ct_pkg::LAST_SEC;
      end else begin
        month_o  <= b3_mon_q;
        day_o    <= b3_day_q;
        hour_o   <= b3_hour_q;
        minute_o <= b3_min_q;
        second_o <= sec_wide[s2ct_pkg::SEC_W-1:0];
      end
    end
  end

  assign out_valid_o = o_v_q;

endmodule

[src/seconds_to_calendar_time.sv]
// ----------------------------------------------------------------------------
// seconds_to_calendar_time
// seconds of the year to month, day and time of day
// ----------------------------------------------------------------------------
// Converts a timestamp counted from January 1 00:00:00 into month, day of
// month, hour, minute, second and the microsecond fraction, one item per
// clock cycle sustained while the output side does not stall. On its way an
// item passes one front stage, a write into the four-entry queue, and four
// back stages ending in the output register. The front stalls only when
// the queue is full, the back only on the output side. The leap rule follows
// calendar_year; the user is to have it written through cfg_we_i only while
// no item is in flight, which the block itself does not enforce. Timestamps
// past the year end come out as December 31 23:59:59 with tuser set, and
// fractions above 999999 are clamped.
// ----------------------------------------------------------------------------
module seconds_to_calendar_time (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config: calendar_year
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // whole_seconds[24:0], micro_fraction[44:25], zeros
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // month_number[3:0], day_of_month[8:4],
                                     // hour_of_day[13:9], minute_of_hour[19:14],
                                     // second_of_minute[25:20], micro_out[45:26], zeros
  output logic [0:0]  m_axis_tuser   // past_year_end[0]
);

  logic [s2ct_pkg::YEAR_W-1:0]  year_q;
  logic                         push_valid, push_ready;
  logic                         pop_valid, pop_ready;
  s2ct_pkg::entry_t             push_entry, pop_entry;
  logic [s2ct_pkg::MON_W-1:0]   month;
  logic [s2ct_pkg::DAY_W-1:0]   day;
  logic [s2ct_pkg::HOUR_W-1:0]  hour;
  logic [s2ct_pkg::MIN_W-1:0]   minute;
  logic [s2ct_pkg::SEC_W-1:0]   second;
  logic [s2ct_pkg::MICRO_W-1:0] micro;
  logic                         past;

  // calendar year register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q <= s2ct_pkg::YEAR_RESET;
    end else if (cfg_we_i) begin
      year_q <= cfg_data_i;
    end
  end

  s2ct_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .secs_i       (s_axis_tdata[24:0]),
    .micro_i      (s_axis_tdata[44:25]),
    .year_i       (year_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  s2ct_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  s2ct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .month_o     (month),
    .day_o       (day),
    .hour_o      (hour),
    .minute_o    (minute),
    .second_o    (second),
    .micro_o     (micro),
    .past_o      (past)
  );

  // output packing
  assign m_axis_tdata = {2'b00, micro, second, minute, hour, day, month};
  assign m_axis_tuser = past;

endmodule

[src/s2ct_checker.sv]
// ----------------------------------------------------------------------------
// s2ct_checker
// port-level checks on the calendar time converter, bound to the top level
// ----------------------------------------------------------------------------
`include "seconds_to_calendar_time_assert.svh"

module s2ct_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [15:0] cfg_data_i,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // field views of the result
  logic [3:0]  mon;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [19:0] micro;
  logic        cfg_seen;
  logic        in_seen;

  assign mon      = m_axis_tdata[3:0];
  assign day      = m_axis_tdata[8:4];
  assign hour     = m_axis_tdata[13:9];
  assign minute   = m_axis_tdata[19:14];
  assign second   = m_axis_tdata[25:20];
  assign micro    = m_axis_tdata[45:26];
  assign cfg_seen = cfg_we_i && (cfg_data_i != 16'd0);
  assign in_seen  = s_axis_tvalid && s_axis_tready && (s_axis_tdata[47:45] != 3'b111);

  // no result is shown while reset is held
  `S2CT_ASSERT_RST(a_rst_idle, clk_i, !rst_ni |-> !m_axis_tvalid, "result valid during reset")

  // a stalled result holds
  `S2CT_ASSERT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // every field of a result is in its range, the day checked only from below
  `S2CT_ASSERT(a_range, clk_i, rst_ni, m_axis_tvalid |-> (mon >= 4'd1) && (mon <= 4'd12) && (day >= 5'd1) && (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59) && (micro <= 20'd999999) && (m_axis_tdata[47:46] == 2'b00), "result field out of range")

  // a saturated result is the last second of the year
  `S2CT_ASSERT(a_sat, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0] |-> (mon == 4'd12) && (day == 5'd31) && (hour == 5'd23) && (minute == 6'd59) && (second == 6'd59), "saturated result not december 31 23:59:59")

  // a result at reset release would mean an invented item
  `S2CT_ASSERT(a_no_early, clk_i, rst_ni, $rose(rst_ni) |-> !m_axis_tvalid || cfg_seen || in_seen, "result without accepted item")

endmodule

bind seconds_to_calendar_time s2ct_checker u_s2ct_checker (.*);

[dv/tb_seconds_to_calendar_time.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seconds_to_calendar_time
// stream check of the seconds-to-calendar converter across calendar years
// ----------------------------------------------------------------------------
// A queue of timestamps feeds a bursty stream driver; a monitor compares
// every result item, field by field, with the oldest prediction. The year
// register is stepped through leap and common years, the extremes among
// them, with the block drained before each write. Boundary timestamps (month
// starts, the year end, saturated fractions) are mixed into random traffic,
// and the receiver stalls on its own pattern, once for a long stretch.
// ----------------------------------------------------------------------------
module tb_seconds_to_calendar_time;
  import s2ct_pkg::*;

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned PHASES        = 9;
  localparam int unsigned PHASE_ITEMS   = 175;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned REPORT_MAX    = 10;

  typedef struct packed {
    logic [MICRO_W-1:0] micro;
    logic [SECS_W-1:0]  secs;
  } stamp_t;

  typedef struct packed {
    logic [MON_W-1:0]   month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic [MICRO_W-1:0] micro;
    logic               past;
  } cal_t;

  typedef enum int unsigned {
    RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC
  } rx_mode_e;

  // dut signals
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b1;
  logic                  cfg_we_i = 1'b0;
  logic [YEAR_W-1:0]     cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;

  // year plan, the reset value first
  logic [YEAR_W-1:0] year_plan [PHASES] =
    '{YEAR_RESET, 16'd1900, 16'd2024, 16'd2023, 16'd0, 16'd65535,
      16'd2100, 16'd2400, 16'd65532};
  int unsigned month_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic [YEAR_W-1:0] model_year = YEAR_RESET;
  stamp_t            stamp_queue [$];
  cal_t              cal_expected [$];
  int unsigned       hold_token = 0;

  // counters
  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned saturated_cnt = 0;
  int unsigned clamped_cnt = 0;
  int unsigned idle_cycles = 0;

  // driver state
  stamp_t      tx_stamp = '0;
  logic        tx_valid_next;
  int unsigned tx_burst_left = 0;
  int unsigned tx_gap_left = 0;

  // receiver state
  rx_mode_e    rx_mode = RX_ALWAYS;
  int unsigned rx_mode_left = 0;
  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  int unsigned hold_seen = 0;
  logic        rx_ready_next;

  // monitor state
  cal_t got_cal;
  cal_t exp_cal;

  seconds_to_calendar_time uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // gregorian leap rule
  function automatic bit leap_year(input logic [YEAR_W-1:0] year);
    return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
  endfunction

  // expected calendar time of one timestamp under a given year
  function automatic cal_t to_calendar(input stamp_t s, input logic [YEAR_W-1:0] year);
    cal_t        r;
    int unsigned doy;
    int unsigned tod;
    int unsigned left;
    int unsigned len;
    int unsigned m;
    bit          lp;
    lp = leap_year(year);
    doy = s.secs / SECS_PER_DAY;
    tod = s.secs % SECS_PER_DAY;
    r.micro = (s.micro > MICRO_MAX) ? MICRO_MAX : s.micro;
    if (doy >= 365 + lp) begin
      r.month = 4'd12;
      r.day = 5'd31;
      r.hour = 5'd23;
      r.minute = 6'd59;
      r.second = 6'd59;
      r.past = 1'b1;
    end else begin
      // walk the months until the day falls inside one
      left = doy;
      m = 0;
      len = month_len[0];
      while (left >= len) begin
        left -= len;
        m++;
        len = month_len[m] + ((m == 1) ? lp : 0);
      end
      r.month = MON_W'(m + 1);
      r.day = DAY_W'(left + 1);
      r.hour = HOUR_W'(tod / 3600);
      r.minute = MIN_W'((tod % 3600) / 60);
      r.second = SEC_W'(tod % 60);
      r.past = 1'b0;
    end
    return r;
  endfunction

  function automatic string cal_text(input cal_t c);
    return $sformatf("%0d/%0d %0d:%0d:%0d.%0d past=%0b",
                     c.month, c.day, c.hour, c.minute, c.second, c.micro, c.past);
  endfunction

  // random timestamp, weighted toward day, month and year boundaries
  function automatic stamp_t random_stamp(input logic [YEAR_W-1:0] year);
    stamp_t      s;
    int unsigned pick;
    int unsigned start;
    int unsigned m;
    int unsigned k;
    int unsigned base;
    bit          lp;
    lp = leap_year(year);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      s.secs = SECS_W'($urandom_range(0, 364 + lp) * SECS_PER_DAY +
                       $urandom_range(0, SECS_PER_DAY - 1));
    end else if (pick < 60) begin
      m = $urandom_range(0, 11);
      start = 0;
      for (k = 0; k < m; k++) begin
        start += month_len[k] + ((k == 1) ? lp : 0);
      end
      base = start * SECS_PER_DAY;
      if (base >= 2 && $urandom_range(0, 1) == 1) begin
        s.secs = SECS_W'(base - $urandom_range(1, 2));
      end else begin
        s.secs = SECS_W'(base + $urandom_range(0, 1));
      end
    end else if (pick < 75) begin
      base = (365 + $urandom_range(0, 1)) * SECS_PER_DAY;
      s.secs = SECS_W'(base - 2 + $urandom_range(0, 4));
    end else begin
      s.secs = SECS_W'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      s.micro = MICRO_W'($urandom_range(0, 999999));
    end else if (pick < 85) begin
      s.micro = MICRO_W'($urandom_range(1000000, 1048575));
    end else begin
      s.micro = MICRO_W'($urandom);
    end
    return s;
  endfunction

  task automatic queue_stamp(input int unsigned secs, input int unsigned micro);
    stamp_t s;
    s.secs = SECS_W'(secs);
    s.micro = MICRO_W'(micro);
    stamp_queue.push_back(s);
  endtask

  task automatic queue_random(input int unsigned count);
    int unsigned i;
    @(negedge clk_i);
    for (i = 0; i < count; i++) begin
      stamp_queue.push_back(random_stamp(model_year));
    end
  endtask

  // wait until nothing is pending, offered or in flight
  task automatic wait_drained();
    @(negedge clk_i);
    while (stamp_queue.size() != 0 || s_axis_tvalid || cal_expected.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_year(input logic [YEAR_W-1:0] year);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= year;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model_year = year;
  endtask

  // stream driver: bursts of random length, random gaps between them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      tx_burst_left = 0;
      tx_gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        cal_expected.push_back(to_calendar(tx_stamp, model_year));
        accepted_cnt++;
        if (tx_stamp.micro > MICRO_MAX) clamped_cnt++;
        if (tx_stamp.secs / SECS_PER_DAY >= 365 + leap_year(model_year)) saturated_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        tx_valid_next = 1'b0;
        if (tx_gap_left > 0) begin
          tx_gap_left--;
        end else if (stamp_queue.size() > 0) begin
          if (tx_burst_left == 0) tx_burst_left = $urandom_range(1, 48);
          tx_stamp = stamp_queue.pop_front();
          tx_valid_next = 1'b1;
          tx_burst_left--;
          if (tx_burst_left == 0) begin
            tx_gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        s_axis_tvalid <= tx_valid_next;
        s_axis_tdata <= {{(IN_DATA_W - SECS_W - MICRO_W){1'b0}}, tx_stamp.micro, tx_stamp.secs};
      end
    end
  end

  // receiver: random stall patterns in turn, long hold on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_mode_left = 0;
      hold_left = 0;
      rx_cycle = 0;
    end else begin
      rx_cycle++;
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = LONG_HOLD;
      end
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(16, 96);
      end else begin
        rx_mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_ready_next = 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:   rx_ready_next = 1'b1;
          RX_COIN:     rx_ready_next = ($urandom_range(0, 1) == 1);
          RX_SPARSE:   rx_ready_next = ($urandom_range(0, 3) == 0);
          default:     rx_ready_next = (rx_cycle % 5 >= 2);
        endcase
      end
      m_axis_tready <= rx_ready_next;
    end
  end

  // monitor: compare each result item with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_cal.month = m_axis_tdata[3:0];
      got_cal.day = m_axis_tdata[8:4];
      got_cal.hour = m_axis_tdata[13:9];
      got_cal.minute = m_axis_tdata[19:14];
      got_cal.second = m_axis_tdata[25:20];
      got_cal.micro = m_axis_tdata[45:26];
      got_cal.past = m_axis_tuser[0];
      checked_cnt++;
      if (cal_expected.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX) begin
          $display("%0t: result with nothing expected: %s", $realtime, cal_text(got_cal));
        end
      end else begin
        exp_cal = cal_expected.pop_front();
        if (got_cal.month !== exp_cal.month || got_cal.day !== exp_cal.day ||
            got_cal.hour !== exp_cal.hour || got_cal.minute !== exp_cal.minute ||
            got_cal.second !== exp_cal.second || got_cal.micro !== exp_cal.micro ||
            got_cal.past !== exp_cal.past) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX) begin
            $display("%0t: mismatch, expected %s, got %s",
                     $realtime, cal_text(exp_cal), cal_text(got_cal));
          end
        end
      end
    end
  end

  // watchdog on cycles without any item moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout with %0d results outstanding", cal_expected.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // stimulus sequence
  initial begin
    int unsigned p;
    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed items under the reset year (leap)
    @(negedge clk_i);
    queue_stamp(0, 0);                              // new year midnight
    queue_stamp(0, 999999);
    queue_stamp(86399, 1);                          // last second of the first day
    queue_stamp(86400, 500000);                     // midnight starts the next day
    queue_stamp(31 * 86400 - 1, 0);                 // end of january
    queue_stamp(31 * 86400, 0);                     // exact midnight of february 1
    queue_stamp(59 * 86400, 123456);                // leap day
    queue_stamp(60 * 86400 - 1, 0);
    queue_stamp(60 * 86400, 0);                     // march 1 in a leap year
    queue_stamp(335 * 86400, 0);                    // december 1 in a leap year
    queue_stamp(365 * 86400 - 1, 0);
    queue_stamp(365 * 86400, 0);                    // december 31 of a leap year
    queue_stamp(366 * 86400 - 1, 999999);           // last second of the year
    queue_stamp(366 * 86400, 42);                   // first second past the year end
    queue_stamp(25'h1FFFFFF, 20'hFFFFF);            // both fields at full scale
    queue_stamp(12345678, 1000000);                 // fraction just over the clamp
    queue_stamp(25'h0AAAAAA, 20'hAAAAA);
    queue_stamp(25'h1555555, 20'h55555);
    queue_stamp(25'h1000000, 20'h80000);

    for (p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        write_year(year_plan[p]);
      end
      if (p == 2) begin
        // let every result come back in the middle of a phase
        queue_random(PHASE_ITEMS / 2);
        wait_drained();
        queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else if (p == 3) begin
        // receiver holds off while the sender keeps offering
        queue_random(150);
        hold_token++;
        queue_random(PHASE_ITEMS - 150);
      end else begin
        queue_random(PHASE_ITEMS);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("covered %0d timestamps over %0d calendar years, %0d results checked",
             accepted_cnt, PHASES, checked_cnt);
    $display("%0d saturated past the year end, %0d with a clamped fraction",
             saturated_cnt, clamped_cnt);
    if (mismatch_cnt == 0 && cal_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
